// ===== hdl/fmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmp_pkg: shared constants and types for the Fibonacci mod prime block
// Modulus, Barrett reduction constants, datapath widths and sequencer states.
// ----------------------------------------------------------------------------
package fmp_pkg;

   localparam int RES_W   = 30;
   localparam int MUL_W   = 33;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SUM_W   = 61;
   localparam int RED_W   = 32;
   localparam int SHIFT_A = 28;
   localparam int SHIFT_Q = 34;

   localparam logic [RES_W-1:0] FIB_MOD = 30'd1000000007;

   // floor(2^62 / FIB_MOD), used with SHIFT_A and SHIFT_Q for the quotient estimate
   localparam logic [MUL_W-1:0] BARRETT_MU =
      MUL_W'((64'd1 << (SHIFT_A + SHIFT_Q)) / 64'(FIB_MOD));

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL1 = 9'b000000010,
      ST_MUL2 = 9'b000000100,
      ST_ADD  = 9'b000001000,
      ST_BAR1 = 9'b000010000,
      ST_BAR2 = 9'b000100000,
      ST_FIX  = 9'b001000000,
      ST_UPD  = 9'b010000000,
      ST_DONE = 9'b100000000
   } state_type;

endpackage

// ===== hdl/fibonacci_mod_prime_top.sv =====
// ----------------------------------------------------------------------------
// fibonacci_mod_prime_top: F(n+2) mod 1000000007 by 2x2 matrix power
// One request at a time, the next accepted once idle. Each exponent bit costs
// four matrix entries on one shared 33x33 multiplier (two products, add, two
// Barrett steps, fix) plus one update.
// Reset (synchronous, active high) returns the sequencer to idle, no rsp_valid.
// ----------------------------------------------------------------------------
module fibonacci_mod_prime_top #(
   parameter int EXP_BITS = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [62:0]               req_index,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [fmp_pkg::RES_W-1:0] rsp_fib_value
);
   import fmp_pkg::*;

   localparam int CNT_W = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

   state_type             state_ff, state_in;
   logic [EXP_BITS-1:0]   exp_ff, exp_in;
   logic [CNT_W-1:0]      bit_ff, bit_in;
   logic [1:0]            ent_ff, ent_in;
   logic [RES_W-1:0]      a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [RES_W-1:0]      t0_ff, t1_ff, t2_ff, t3_ff, t0_in, t1_in, t2_in, t3_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]      rsp_value_ff, rsp_value_in;

   logic [MUL_W-1:0]      op_a, op_b;
   logic [RES_W-1:0]      x1, x2, y1, y2;
   logic [RED_W-1:0]      r_raw;
   logic [RES_W-1:0]      r_fix;
   logic [63:0]           exp_full;

   function automatic logic [RES_W-1:0] mod_add(input logic [RES_W-1:0] x,
                                                input logic [RES_W-1:0] y);
      logic [RES_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, FIB_MOD}) begin
         s = s - {1'b0, FIB_MOD};
      end
      return s[RES_W-1:0];
   endfunction

   assign exp_full = {1'b0, req_index} + 64'd1;

   assign x1 = ent_ff[1] ? c_ff : a_ff;
   assign x2 = ent_ff[1] ? d_ff : b_ff;
   assign y1 = ent_ff[0] ? b_ff : a_ff;
   assign y2 = ent_ff[0] ? d_ff : c_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         ST_MUL1: begin
            op_a = {{(MUL_W-RES_W){1'b0}}, x1};
            op_b = {{(MUL_W-RES_W){1'b0}}, y1};
         end
         ST_MUL2: begin
            op_a = {{(MUL_W-RES_W){1'b0}}, x2};
            op_b = {{(MUL_W-RES_W){1'b0}}, y2};
         end
         ST_BAR1: begin
            op_a = sum_ff[SUM_W-1:SHIFT_A];
            op_b = BARRETT_MU;
         end
         ST_BAR2: begin
            op_a = {1'b0, prod_ff[PROD_W-1:SHIFT_Q]};
            op_b = {{(MUL_W-RES_W){1'b0}}, FIB_MOD};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // residue after quotient estimate lies below three times the modulus
   always_comb begin
      r_raw = sum_ff[RED_W-1:0] - prod_ff[RED_W-1:0];
      priority if (r_raw >= {1'b0, FIB_MOD, 1'b0}) begin
         r_fix = RES_W'(r_raw - {1'b0, FIB_MOD, 1'b0});
      end else if (r_raw >= {2'b00, FIB_MOD}) begin
         r_fix = RES_W'(r_raw - {2'b00, FIB_MOD});
      end else begin
         r_fix = r_raw[RES_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      bit_in       = bit_ff;
      ent_in       = ent_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      d_in         = d_ff;
      t0_in        = t0_ff;
      t1_in        = t1_ff;
      t2_in        = t2_ff;
      t3_in        = t3_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               exp_in   = exp_full[EXP_BITS-1:0];
               bit_in   = CNT_W'(EXP_BITS - 1);
               ent_in   = 2'd0;
               a_in     = RES_W'(1);
               b_in     = '0;
               c_in     = '0;
               d_in     = RES_W'(1);
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: begin
            sum_in   = prod_ff[SUM_W-1:0];
            state_in = ST_ADD;
         end
         ST_ADD: begin
            sum_in   = sum_ff + prod_ff[SUM_W-1:0];
            state_in = ST_BAR1;
         end
         ST_BAR1: state_in = ST_BAR2;
         ST_BAR2: state_in = ST_FIX;
         ST_FIX: begin
            unique case (ent_ff)
               2'd0:    t0_in = r_fix;
               2'd1:    t1_in = r_fix;
               2'd2:    t2_in = r_fix;
               default: t3_in = r_fix;
            endcase
            if (ent_ff == 2'd3) begin
               state_in = ST_UPD;
            end else begin
               ent_in   = ent_ff + 2'd1;
               state_in = ST_MUL1;
            end
         end
         ST_UPD: begin
            if (exp_ff[EXP_BITS-1]) begin
               a_in = mod_add(t0_ff, t1_ff);
               b_in = t0_ff;
               c_in = mod_add(t2_ff, t3_ff);
               d_in = t2_ff;
            end else begin
               a_in = t0_ff;
               b_in = t1_ff;
               c_in = t2_ff;
               d_in = t3_ff;
            end
            exp_in = exp_ff << 1;
            ent_in = 2'd0;
            if (bit_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               bit_in   = bit_ff - CNT_W'(1);
               state_in = ST_MUL1;
            end
         end
         ST_DONE: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = a_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      exp_ff       <= exp_in;
      bit_ff       <= bit_in;
      ent_ff       <= ent_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      d_ff         <= d_in;
      t0_ff        <= t0_in;
      t1_ff        <= t1_in;
      t2_ff        <= t2_in;
      t3_ff        <= t3_in;
      sum_ff       <= sum_in;
      prod_ff      <= op_a * op_b;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fib_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_rsp_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_value_ff < FIB_MOD))
      else $error("result not reduced");

   a_quot_not_over: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (prod_ff[SUM_W-1:0] <= sum_ff))
      else $error("Barrett quotient too large");

   a_fix_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIX) |-> (r_fix < FIB_MOD))
      else $error("reduced entry out of range");

   a_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=>
         (state_ff == ST_MUL1) && (bit_ff == CNT_W'(EXP_BITS - 1)) && (ent_ff == 2'd0))
      else $error("request did not start the sequence");
`endif

endmodule
